@@ src/ifmt_pkg.sv @@
// Shared types, constants and the digit-to-character function of the integer field formatter.
// Used by the controller, the datapath and the top level; depends on nothing else.
package ifmt_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned WIDTH_W = 7;
   localparam int unsigned PREC_W  = 7;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned LEN_W   = 8;

   localparam logic [MODE_W-1:0] MODE_SDEC = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UDEC = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OCT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HEXL = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HEXU = 3'd4;

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_X       = 8'h58;
   localparam logic [CHAR_W-1:0] HEX_ADJ    = 8'h07;
   localparam logic [CHAR_W-1:0] LOWER_MASK = 8'h20;

   typedef struct packed {
      logic [VALUE_W-1:0]       value;
      logic [MODE_W-1:0]        mode;
      logic                     left_justify;
      logic                     plus_sign;
      logic                     space_sign;
      logic                     alternate_form;
      logic                     zero_pad;
      logic [WIDTH_W-1:0]       width;
      logic signed [PREC_W-1:0] precision;
   } req_type;

   typedef struct packed {
      logic load;
      logic split;
      logic conv_step;
      logic norm_step;
      logic plan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_dec;
      logic conv_last;
      logic norm_done;
      logic out_free;
      logic emit_last;
   } sts_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic lower);
      logic [CHAR_W-1:0] c;
      c = CH_ZERO + CHAR_W'(d);
      if (c > CH_NINE) begin
         c = (c + HEX_ADJ) | (lower ? LOWER_MASK : CH_NUL);
      end
      return c;
   endfunction

endpackage

@@ src/integer_field_formatter_top.sv @@
// Top level of the integer field formatter: joins the controller and the datapath.
// Depends on ifmt_pkg, ifmt_ctrl and ifmt_dpath.
//
//   Channel  Direction  Payload
//   req_     in         tdata: value, flags, width, precision; tuser: mode
//   rsp_     out        tdata: out_char; tlast: last; tuser: empty_res
//
// One transaction is taken at a time. Decimal operands pass through the bit-serial binary to
// decimal converter; octal and hex skip it. Leading zero digits are then stripped at one per
// cycle (at most 22), the field is laid out, and the characters leave at one per cycle while
// the output is not stalled, up to MAX_FIELD of them.
// Reset is synchronous and clears only the controller and the output valid flag.
// A stalled result holds the character stream; the next request is taken once the last
// character of a field sits in the output register.
module integer_field_formatter_top #(
   parameter int unsigned MAX_FIELD  = 64,
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // value[63:0], left_justify[64], plus_sign[65], space_sign[66], alternate_form[67],
   // zero_pad[68], width[75:69], precision[82:76], zeros[87:83]
   input  logic [87:0] req_tdata,
   // mode[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_char[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // empty_res[0]
   output logic [0:0]  rsp_tuser
);

   ifmt_pkg::req_type req;
   ifmt_pkg::cmd_type cmd;
   ifmt_pkg::sts_type sts;

   always_comb begin
      req.value          = req_tdata[63:0];
      req.left_justify   = req_tdata[64];
      req.plus_sign      = req_tdata[65];
      req.space_sign     = req_tdata[66];
      req.alternate_form = req_tdata[67];
      req.zero_pad       = req_tdata[68];
      req.width          = req_tdata[75:69];
      req.precision      = req_tdata[82:76];
      req.mode           = req_tuser;
   end

   ifmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ifmt_dpath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_FIELD  (MAX_FIELD)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_empty  (rsp_tuser[0])
   );

endmodule

@@ src/ifmt_ctrl.sv @@
// Sequencing state machine of the integer field formatter.
// Depends on ifmt_pkg for the command and status structs.
module ifmt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ifmt_pkg::sts_type sts,
   output ifmt_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SPLIT = 6'b000010,
      ST_CONV  = 6'b000100,
      ST_NORM  = 6'b001000,
      ST_PLAN  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = sts.is_dec ? ST_CONV : ST_NORM;
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_last) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (sts.norm_done) begin
               state_in = ST_PLAN;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/ifmt_dpath.sv @@
// Datapath of the integer field formatter: operand registers, binary to digit conversion,
// field layout counters and the character output register. Depends on ifmt_pkg.
module ifmt_dpath #(
   parameter int unsigned VALUE_BITS = 64,
   parameter int unsigned MAX_FIELD  = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ifmt_pkg::req_type                req,
   input  ifmt_pkg::cmd_type                cmd,
   output ifmt_pkg::sts_type                sts,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ifmt_pkg::CHAR_W-1:0]      rsp_char,
   output logic                             rsp_last,
   output logic                             rsp_empty
);

   localparam int unsigned DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int unsigned OCT_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int unsigned NDIG  = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
   localparam int unsigned DIG_W = NDIG * 4;
   localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
   localparam int unsigned REM_W = $clog2(MAX_FIELD + 1);
   localparam int unsigned LEN_W = ifmt_pkg::LEN_W;
   localparam int unsigned CHAR_W = ifmt_pkg::CHAR_W;

   logic                           dec_ff, oct_ff, lower_ff;
   logic                           left_ff, alt_ff, zpad_ff, prec_given_ff;
   logic [ifmt_pkg::WIDTH_W-1:0]   width_ff;
   logic [ifmt_pkg::PREC_W-2:0]    prec_ff;
   logic [VALUE_BITS-1:0]          mag_ff;
   logic [CHAR_W-1:0]              pre0_ff, pre1_ff;
   logic [1:0]                     plen_ff;
   logic [DIG_W-1:0]               dig_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic [LEN_W-1:0]               lead_ff, zeros_ff;
   logic [REM_W-1:0]               rem_ff;
   logic                           empty_ff;
   logic                           out_valid_ff, out_last_ff, out_empty_ff;
   logic [CHAR_W-1:0]              out_char_ff;

   logic                           dec_in, oct_in, lower_in, sgn_in, neg_in;
   logic [VALUE_BITS-1:0]          val_in, mag_in;
   logic [DIG_W-1:0]               mag_pad, split_dig, adj_dig;
   logic [3:0]                     top_dig;

   logic                           alt0, hexpre;
   logic [1:0]                     plen_p;
   logic [LEN_W-1:0]               dlen_w, prec_w, deff, nd, nfield, fpad, zeros, total;
   logic [LEN_W-1:0]               lead_p;
   logic [REM_W-1:0]               rem_p;
   logic                           empty_p;
   logic [CHAR_W-1:0]              emit_char;

   // Operand decode at acceptance.
   always_comb begin
      oct_in   = (req.mode == ifmt_pkg::MODE_OCT);
      lower_in = (req.mode == ifmt_pkg::MODE_HEXL);
      dec_in   = !oct_in && !lower_in && (req.mode != ifmt_pkg::MODE_HEXU);
      sgn_in   = (req.mode == ifmt_pkg::MODE_SDEC);
      val_in   = req.value[VALUE_BITS-1:0];
      neg_in   = sgn_in && val_in[VALUE_BITS-1];
      mag_in   = neg_in ? (~val_in + 1'b1) : val_in;
   end

   // Octal and hex digits are plain bit groups of the magnitude.
   always_comb begin
      mag_pad = DIG_W'(mag_ff);
      for (int i = 0; i < NDIG; i++) begin
         if (oct_ff) begin
            split_dig[4*i +: 4] = {1'b0, mag_pad[3*i +: 3]};
         end else begin
            split_dig[4*i +: 4] = mag_pad[4*i +: 4];
         end
      end
   end

   // Shift-and-add-3 correction applied to every decimal digit before each shift.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            adj_dig[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            adj_dig[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   assign top_dig = dig_ff[DIG_W-1 -: 4];

   // Field layout, worked out once the significant digit count is known.
   always_comb begin
      dlen_w = LEN_W'(cnt_ff);
      alt0   = oct_ff && alt_ff && ((cnt_ff != '0) || (prec_given_ff && (prec_ff == '0)));
      hexpre = !dec_ff && !oct_ff && alt_ff && (cnt_ff != '0);
      plen_p = hexpre ? 2'd2 : plen_ff;
      prec_w = prec_given_ff ? LEN_W'(prec_ff) : LEN_W'(1);
      deff   = dlen_w + LEN_W'(alt0);
      nd     = (prec_w > deff) ? prec_w : deff;
      nfield = nd + LEN_W'(plen_p);
      fpad   = (LEN_W'(width_ff) > nfield) ? (LEN_W'(width_ff) - nfield) : '0;
      zeros  = nd - dlen_w;
      if (zpad_ff && !prec_given_ff && !left_ff) begin
         zeros = zeros + fpad;
         fpad  = '0;
      end
      total   = fpad + LEN_W'(plen_p) + zeros + dlen_w;
      lead_p  = left_ff ? '0 : fpad;
      empty_p = (total == '0);
      if (empty_p) begin
         rem_p = REM_W'(1);
      end else if (total > LEN_W'(MAX_FIELD)) begin
         rem_p = REM_W'(MAX_FIELD);
      end else begin
         rem_p = REM_W'(total);
      end
   end

   always_comb begin
      if (empty_ff) begin
         emit_char = ifmt_pkg::CH_NUL;
      end else if (lead_ff != '0) begin
         emit_char = ifmt_pkg::CH_SPACE;
      end else if (plen_ff != '0) begin
         emit_char = pre0_ff;
      end else if (zeros_ff != '0) begin
         emit_char = ifmt_pkg::CH_ZERO;
      end else if (cnt_ff != '0) begin
         emit_char = ifmt_pkg::digit_char(top_dig, lower_ff);
      end else begin
         emit_char = ifmt_pkg::CH_SPACE;
      end
   end

   always_comb begin
      sts.is_dec    = dec_ff;
      sts.conv_last = (cnt_ff == CNT_W'(1));
      sts.norm_done = (top_dig != '0) || (cnt_ff == '0);
      sts.out_free  = !out_valid_ff || rsp_tready;
      sts.emit_last = (rem_ff == REM_W'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dec_ff        <= dec_in;
         oct_ff        <= oct_in;
         lower_ff      <= lower_in;
         left_ff       <= req.left_justify;
         alt_ff        <= req.alternate_form;
         zpad_ff       <= req.zero_pad;
         width_ff      <= req.width;
         prec_given_ff <= !req.precision[ifmt_pkg::PREC_W-1];
         prec_ff       <= req.precision[ifmt_pkg::PREC_W-2:0];
         mag_ff        <= mag_in;
         plen_ff       <= {1'b0, neg_in || (sgn_in && (req.plus_sign || req.space_sign))};
         if (neg_in) begin
            pre0_ff <= ifmt_pkg::CH_MINUS;
         end else if (req.plus_sign) begin
            pre0_ff <= ifmt_pkg::CH_PLUS;
         end else begin
            pre0_ff <= ifmt_pkg::CH_SPACE;
         end
      end
      if (cmd.split) begin
         if (dec_ff) begin
            dig_ff <= '0;
            cnt_ff <= CNT_W'(VALUE_BITS);
         end else begin
            dig_ff <= split_dig;
            cnt_ff <= CNT_W'(NDIG);
         end
      end
      if (cmd.conv_step) begin
         dig_ff <= {adj_dig[DIG_W-2:0], mag_ff[VALUE_BITS-1]};
         mag_ff <= mag_ff << 1;
         cnt_ff <= sts.conv_last ? CNT_W'(NDIG) : (cnt_ff - 1'b1);
      end
      if (cmd.norm_step) begin
         dig_ff <= dig_ff << 4;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.plan) begin
         lead_ff  <= lead_p;
         zeros_ff <= zeros;
         rem_ff   <= rem_p;
         empty_ff <= empty_p;
         plen_ff  <= plen_p;
         if (hexpre) begin
            pre0_ff <= ifmt_pkg::CH_ZERO;
            pre1_ff <= ifmt_pkg::CH_X | (lower_ff ? ifmt_pkg::LOWER_MASK : ifmt_pkg::CH_NUL);
         end
      end
      if (cmd.emit) begin
         rem_ff       <= rem_ff - 1'b1;
         out_char_ff  <= emit_char;
         out_last_ff  <= sts.emit_last;
         out_empty_ff <= empty_ff;
         if (empty_ff) begin
            lead_ff <= lead_ff;
         end else if (lead_ff != '0) begin
            lead_ff <= lead_ff - 1'b1;
         end else if (plen_ff != '0) begin
            pre0_ff <= pre1_ff;
            plen_ff <= plen_ff - 1'b1;
         end else if (zeros_ff != '0) begin
            zeros_ff <= zeros_ff - 1'b1;
         end else if (cnt_ff != '0) begin
            dig_ff <= dig_ff << 4;
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_char   = out_char_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_empty  = out_empty_ff;

endmodule

@@ src/ifmt_checker.sv @@
// Port-level checks of the integer field formatter and the bind that attaches them.
// Depends only on the top level's ports and its MAX_FIELD parameter.
module ifmt_checker #(
   parameter int unsigned MAX_FIELD = 64
) (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);

   localparam int unsigned CNT_W = $clog2(MAX_FIELD + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] chars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         busy_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tlast) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         chars_ff <= rsp_tlast ? '0 : (chars_ff + 1'b1);
      end
   end

   // A new request is only taken once the previous field has shown its final character.
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!busy_ff || (rsp_tvalid && rsp_tlast)))
      else $error("request taken while a field is still being produced");

   a_empty_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tlast && (rsp_tdata == 8'h00) && (chars_ff == '0)))
      else $error("empty marker not on a lone null final transaction");

   a_field_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |-> (chars_ff < CNT_W'(MAX_FIELD - 1)))
      else $error("field longer than the maximum width");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind integer_field_formatter_top ifmt_checker #(
   .MAX_FIELD (MAX_FIELD)
) u_ifmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
